>>> rtl/gamepad_drive_command_mapper_macros.svh
// Assertion macros shared by the drive command mapper RTL.
// Depends on nothing; included by the top level for its end-of-file checks.
`ifndef GAMEPAD_DRIVE_COMMAND_MAPPER_MACROS_SVH
`define GAMEPAD_DRIVE_COMMAND_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GDCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gdcm: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gdcm: next-cycle check failed");

`endif

>>> rtl/gdcm_pkg.sv
// Types and constants of the gamepad drive command mapper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gdcm_pkg;

    // Q15 fixed point: 32768 stands for 1.0.
    localparam logic [16:0] Q15_ONE    = 17'd32768;
    localparam logic [14:0] HALF_SCALE = 15'd16384;
    localparam int          GAIN_SHIFT = 14;
    localparam logic [31:0] GAIN_ROUND = 32'd8192;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 1'd1;
    localparam logic [14:0] DEADZONE_RESET = 15'd3277;
    localparam logic [15:0] GAIN_RESET     = 16'd18204;

    // Drive modes cycle from the first to the last and wrap.
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd3;

    typedef struct packed {
        logic a;
        logic b;
        logic x;
        logic y;
    } t_buttons;

    typedef struct packed {
        logic       armed;
        logic       estop;
        logic       lights_on;
        logic [1:0] drive_mode;
        logic       clear_estop_latch;
    } t_flags;

    // Positive full-scale correction: r * 32768 / 32767 rounded to nearest.
    function automatic logic [15:0] q15_norm(input logic [14:0] r);
        logic [15:0] res;
        res = {1'b0, r};
        if (r >= HALF_SCALE) begin
            res = {1'b0, r} + 16'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gdcm_in_if.sv
// Input channel of the drive command mapper: one controller sample per transaction.
// Carries valid, ready and the sample fields; depends on nothing.
`default_nettype none

interface gdcm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] stick_x;
    logic [14:0]        trigger_right;
    logic [14:0]        trigger_left;
    logic               button_a;
    logic               button_b;
    logic               button_x;
    logic               button_y;

    modport source (
        output valid, stick_x, trigger_right, trigger_left,
        output button_a, button_b, button_x, button_y,
        input  ready
    );
    modport sink (
        input  valid, stick_x, trigger_right, trigger_left,
        input  button_a, button_b, button_x, button_y,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/gdcm_out_if.sv
// Output channel of the drive command mapper: one drive command per transaction.
// Carries valid, ready and the command fields; depends on nothing.
`default_nettype none

interface gdcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] steering;
    logic signed [16:0] throttle;
    logic               armed;
    logic               estop;
    logic               lights_on;
    logic [1:0]         drive_mode;
    logic               clear_estop_latch;

    modport source (
        output valid, steering, throttle, armed, estop, lights_on,
        output drive_mode, clear_estop_latch,
        input  ready
    );
    modport sink (
        input  valid, steering, throttle, armed, estop, lights_on,
        input  drive_mode, clear_estop_latch,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/gamepad_drive_command_mapper.sv
// Gamepad drive command mapper: one controller sample in, one drive command out.
// A sample passes the input register, then waits as a command in the result register.
// Throughput is one sample per cycle while o_out.ready is high, set by that register pair.
// Synchronous reset disarms, clears estop and lights, sets drive mode one and
// loads the deadzone (3277) and gain (18204) registers; no clearing pass is needed.
`default_nettype none

module gamepad_drive_command_mapper (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    gdcm_in_if.sink                                 i_in,
    gdcm_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [gdcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gdcm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // Configuration registers.
    logic [14:0] r_deadzone;
    logic [15:0] r_gain;

    // Input stage.
    logic               r_in_valid;
    logic signed [15:0] r_stick_x;
    logic [14:0]        r_trig_r;
    logic [14:0]        r_trig_l;
    gdcm_pkg::t_buttons r_btn;

    // Result stage.
    logic               r_out_valid;
    logic signed [16:0] r_steering;
    logic signed [16:0] r_throttle;
    gdcm_pkg::t_flags   r_flags;

    logic               out_free;
    logic               advance;
    logic               take;
    logic signed [16:0] n_steering;
    logic signed [16:0] n_throttle;
    gdcm_pkg::t_flags   n_flags;

    // Pipeline handshake: each stage moves when the one after it can take.
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign take       = i_in.valid && i_in.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= gdcm_pkg::DEADZONE_RESET;
            r_gain     <= gdcm_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gdcm_pkg::REG_DEADZONE: r_deadzone <= i_cfg_wdata[14:0];
                gdcm_pkg::REG_GAIN:     r_gain     <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stick_x <= i_in.stick_x;
            r_trig_r  <= i_in.trigger_right;
            r_trig_l  <= i_in.trigger_left;
            r_btn     <= '{a: i_in.button_a, b: i_in.button_b,
                           x: i_in.button_x, y: i_in.button_y};
        end
    end

    gdcm_analog u_analog (
        .i_stick_x       (r_stick_x),
        .i_trigger_right (r_trig_r),
        .i_trigger_left  (r_trig_l),
        .i_deadzone      (r_deadzone),
        .i_gain          (r_gain),
        .o_steering      (n_steering),
        .o_throttle      (n_throttle)
    );

    gdcm_buttons u_buttons (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_btn   (r_btn),
        .o_flags (n_flags)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_steering <= n_steering;
            r_throttle <= n_throttle;
            r_flags    <= n_flags;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.steering          = r_steering;
    assign o_out.throttle          = r_throttle;
    assign o_out.armed             = r_flags.armed;
    assign o_out.estop             = r_flags.estop;
    assign o_out.lights_on         = r_flags.lights_on;
    assign o_out.drive_mode        = r_flags.drive_mode;
    assign o_out.clear_estop_latch = r_flags.clear_estop_latch;

    // Checks on the pipeline, the flag logic and the steering range.
`include "gamepad_drive_command_mapper_macros.svh"

    `GDCM_ASSERT_NOW(a_full_stall_blocks, i_clk, i_rst_n, r_in_valid && r_out_valid && !o_out.ready, !i_in.ready)
    `GDCM_ASSERT_NOW(a_armed_estop_excl, i_clk, i_rst_n, o_out.valid, !(o_out.armed && o_out.estop))
    `GDCM_ASSERT_NOW(a_pulse_flags, i_clk, i_rst_n, o_out.valid && o_out.clear_estop_latch, o_out.armed != o_out.estop)
    `GDCM_ASSERT_NOW(a_steer_range, i_clk, i_rst_n, o_out.valid, (o_out.steering <= 17'sd32768) && (o_out.steering >= -17'sd32768))
    `GDCM_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

`default_nettype wire

>>> rtl/gdcm_analog.sv
// Analogue path: stick normalisation, deadzone with gain and saturation, and throttle.
// Purely combinational; depends on gdcm_pkg.
`default_nettype none

module gdcm_analog (
    input  wire logic signed [15:0] i_stick_x,
    input  wire logic [14:0]        i_trigger_right,
    input  wire logic [14:0]        i_trigger_left,
    input  wire logic [14:0]        i_deadzone,
    input  wire logic [15:0]        i_gain,
    output logic signed [16:0]      o_steering,
    output logic signed [16:0]      o_throttle
);

    logic        neg;
    logic [16:0] neg_ext;
    logic [15:0] mag;
    logic        below;
    logic [15:0] excess;
    logic [31:0] prod;
    logic [31:0] rounded;
    logic [17:0] scaled;
    logic [16:0] sat_mag;

    // Magnitude of the normalised stick: negative values pass unchanged.
    assign neg     = i_stick_x[15];
    assign neg_ext = 17'd0 - {i_stick_x[15], i_stick_x};
    assign mag     = neg ? neg_ext[15:0] : gdcm_pkg::q15_norm(i_stick_x[14:0]);

    // Deadzone removal, gain with round half away from zero, then saturation.
    assign below   = mag < {1'b0, i_deadzone};
    assign excess  = mag - {1'b0, i_deadzone};
    assign prod    = excess * i_gain;
    assign rounded = prod + gdcm_pkg::GAIN_ROUND;
    assign scaled  = rounded[31:gdcm_pkg::GAIN_SHIFT];
    assign sat_mag = (scaled > {1'b0, gdcm_pkg::Q15_ONE}) ? gdcm_pkg::Q15_ONE : scaled[16:0];

    always_comb begin
        if (below) begin
            o_steering = '0;
        end else if (neg) begin
            o_steering = $signed(17'd0 - sat_mag);
        end else begin
            o_steering = $signed(sat_mag);
        end
    end

    // Throttle is the difference of the two normalised triggers.
    assign o_throttle = $signed({1'b0, gdcm_pkg::q15_norm(i_trigger_right)}
                              - {1'b0, gdcm_pkg::q15_norm(i_trigger_left)});

endmodule

`default_nettype wire

>>> rtl/gdcm_buttons.sv
// Button edge detection and the arm, estop, lights and drive mode state.
// State advances once per transaction that leaves the input stage; depends on gdcm_pkg.
`default_nettype none

module gdcm_buttons (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire gdcm_pkg::t_buttons i_btn,
    output gdcm_pkg::t_flags       o_flags
);

    gdcm_pkg::t_buttons r_hist;
    logic               r_armed;
    logic               r_estop;
    logic               r_lights;
    logic [1:0]         r_mode;

    gdcm_pkg::t_buttons rise;
    logic               n_armed;
    logic               n_estop;
    logic               n_lights;
    logic [1:0]         n_mode;
    logic               n_pulse;

    // A button acts only on the sample where it goes from released to pressed.
    assign rise = i_btn & ~r_hist;

    // Arming is applied first; an estop in the same sample then wins.
    always_comb begin
        n_armed  = r_armed;
        n_estop  = r_estop;
        n_pulse  = 1'b0;
        n_lights = r_lights ^ rise.y;
        n_mode   = r_mode;
        if (rise.a) begin
            n_armed = ~r_armed;
            if (!r_armed) begin
                n_estop = 1'b0;
                n_pulse = 1'b1;
            end
        end
        if (rise.b) begin
            n_estop = 1'b1;
            n_armed = 1'b0;
        end
        if (rise.x) begin
            n_mode = (r_mode == gdcm_pkg::MODE_LAST) ? gdcm_pkg::MODE_FIRST : r_mode + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_armed  <= 1'b0;
            r_estop  <= 1'b0;
            r_lights <= 1'b0;
            r_mode   <= gdcm_pkg::MODE_FIRST;
        end else if (i_en) begin
            r_hist   <= i_btn;
            r_armed  <= n_armed;
            r_estop  <= n_estop;
            r_lights <= n_lights;
            r_mode   <= n_mode;
        end
    end

    assign o_flags = '{armed: n_armed, estop: n_estop, lights_on: n_lights,
                       drive_mode: n_mode, clear_estop_latch: n_pulse};

endmodule

`default_nettype wire

>>> sim/gdcm_cmd_checker.sv
// Scoreboard for the gamepad drive command mapper: predicts every drive command and checks it.
// Depends on gdcm_pkg and on the gdcm_in_if and gdcm_out_if channel interfaces.
`default_nettype none

module gdcm_cmd_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    gdcm_in_if                                   i_sample,
    gdcm_out_if                                  i_command,
    input  wire logic                            i_cfg_we,
    input  wire logic [gdcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gdcm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gdcm_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [16:0] steering;
        logic signed [16:0] throttle;
        logic               armed;
        logic               estop;
        logic               lights_on;
        logic [1:0]         drive_mode;
        logic               clear_estop_latch;
    } cmd_t;

    // Shadow copy of the thresholds and of the vehicle state.
    logic [14:0] dz;
    logic [15:0] gain;
    t_buttons    held;
    logic        armed;
    logic        estop;
    logic        lights;
    logic [1:0]  mode;

    cmd_t pending_cmds[$];
    int   fails   = 0;
    int   checked = 0;

    // Normalise the stick, apply the deadzone and gain, and saturate at full scale.
    function automatic logic signed [16:0] steer_from_stick(input logic signed [15:0] raw);
        int     v;
        int     mag;
        longint scaled;
        v = int'(raw);
        if (v >= int'(HALF_SCALE)) v = v + 1;
        mag = (v < 0) ? -v : v;
        if (mag < int'(dz)) return '0;
        scaled = (longint'(mag - int'(dz)) * longint'(gain) + longint'(GAIN_ROUND))
                 >>> GAIN_SHIFT;
        if (scaled > longint'(Q15_ONE)) scaled = longint'(Q15_ONE);
        return 17'((v < 0) ? -scaled : scaled);
    endfunction

    // Throttle is the normalised right trigger less the normalised left trigger.
    function automatic logic signed [16:0] throttle_from_triggers(input logic [14:0] tr,
                                                                  input logic [14:0] tl);
        int fwd;
        int brk;
        fwd = int'(tr);
        brk = int'(tl);
        if (fwd >= int'(HALF_SCALE)) fwd = fwd + 1;
        if (brk >= int'(HALF_SCALE)) brk = brk + 1;
        return 17'(fwd - brk);
    endfunction

    // Advance the button state by one sample and build the command it produces.
    // A is applied before B, so pressing both always ends disarmed with estop set.
    function automatic cmd_t next_command(input logic signed [15:0] stick,
                                          input logic [14:0] tr, input logic [14:0] tl,
                                          input t_buttons now);
        t_buttons rise;
        cmd_t     c;
        rise = t_buttons'(now & ~held);
        held = now;
        c.clear_estop_latch = 1'b0;
        if (rise.a) begin
            armed = ~armed;
            if (armed) begin
                estop = 1'b0;
                c.clear_estop_latch = 1'b1;
            end
        end
        if (rise.b) begin
            estop = 1'b1;
            armed = 1'b0;
        end
        if (rise.y) lights = ~lights;
        if (rise.x) mode = (mode == MODE_LAST) ? MODE_FIRST : mode + 2'd1;
        c.steering   = steer_from_stick(stick);
        c.throttle   = throttle_from_triggers(tr, tl);
        c.armed      = armed;
        c.estop      = estop;
        c.lights_on  = lights;
        c.drive_mode = mode;
        return c;
    endfunction

    // Follow register writes and both channels; results are compared in order.
    always @(posedge i_clk) begin
        cmd_t want;
        cmd_t got;
        if (!i_rst_n) begin
            dz     = DEADZONE_RESET;
            gain   = GAIN_RESET;
            held   = '0;
            armed  = 1'b0;
            estop  = 1'b0;
            lights = 1'b0;
            mode   = MODE_FIRST;
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEADZONE: dz = i_cfg_wdata[14:0];
                    REG_GAIN:     gain = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end

            if (i_command.valid && i_command.ready) begin
                got.steering          = i_command.steering;
                got.throttle          = i_command.throttle;
                got.armed             = i_command.armed;
                got.estop             = i_command.estop;
                got.lights_on         = i_command.lights_on;
                got.drive_mode        = i_command.drive_mode;
                got.clear_estop_latch = i_command.clear_estop_latch;
                if (pending_cmds.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: drive command transaction with none outstanding", $time);
                end else begin
                    want = pending_cmds.pop_front();
                    checked++;
                    if (want !== got) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $write("%0t: command %0d mismatch (expected/actual): steer %0d/%0d thr %0d/%0d ",
                                   $time, checked, want.steering, got.steering,
                                   want.throttle, got.throttle);
                            $display("armed %0b/%0b estop %0b/%0b lights %0b/%0b mode %0d/%0d latch %0b/%0b",
                                     want.armed, got.armed, want.estop, got.estop,
                                     want.lights_on, got.lights_on,
                                     want.drive_mode, got.drive_mode,
                                     want.clear_estop_latch, got.clear_estop_latch);
                        end
                    end
                end
            end

            if (i_sample.valid && i_sample.ready) begin
                pending_cmds.push_back(next_command(i_sample.stick_x, i_sample.trigger_right,
                                                    i_sample.trigger_left,
                                                    t_buttons'({i_sample.button_a,
                                                                i_sample.button_b,
                                                                i_sample.button_x,
                                                                i_sample.button_y})));
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_cmds.size();
        o_checked    <= checked;
    end

endmodule

`default_nettype wire

>>> sim/tb_gamepad_drive_command_mapper.sv
// Testbench top of the gamepad drive command mapper: clock, reset, samples and thresholds.
// Depends on gdcm_pkg, the channel interfaces, the mapper RTL and gdcm_cmd_checker.
`default_nettype none

module tb_gamepad_drive_command_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import gdcm_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int LONG_HOLD   = 64;
    localparam int WATCHDOG_NS = 3_000_000;

    localparam t_buttons BTN_NONE = 4'b0000;
    localparam t_buttons BTN_A    = 4'b1000;
    localparam t_buttons BTN_B    = 4'b0100;
    localparam t_buttons BTN_X    = 4'b0010;
    localparam t_buttons BTN_Y    = 4'b0001;

    typedef struct packed {
        logic signed [15:0] stick;
        logic [14:0]        tr;
        logic [14:0]        tl;
        t_buttons           btn;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    // Pacing controls and counters for the sample and command sides.
    bit          gaps_on    = 1'b1;
    bit          stalls_on  = 1'b1;
    bit          hold_req   = 1'b0;
    int          holds_done = 0;
    int          sent       = 0;
    int          settings   = 0;
    logic [14:0] dz_now     = DEADZONE_RESET;
    t_buttons    last_btn   = BTN_NONE;

    gdcm_in_if  u_sample_if ();
    gdcm_out_if u_cmd_if ();

    gamepad_drive_command_mapper u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (u_sample_if),
        .o_out       (u_cmd_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    gdcm_cmd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_sample     (u_sample_if),
        .i_command    (u_cmd_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Give up if the run hangs.
    initial begin
        #(WATCHDOG_NS);
        $display("Regression FAIL");
        $finish;
    end

    function automatic sample_t make_sample(input int stick, input int tr, input int tl,
                                            input t_buttons btn);
        sample_t s;
        s.stick = 16'(stick);
        s.tr    = 15'(tr);
        s.tl    = 15'(tl);
        s.btn   = btn;
        return s;
    endfunction

    // Random sample aimed at the deadzone edge, half scale, small values and the extremes, else fully random.
    // Each button either keeps its previous level or takes a fresh one.
    function automatic sample_t random_sample();
        sample_t  s;
        int       mag;
        logic [3:0] keep;
        mag = 0;
        case ($urandom_range(0, 5))
            1: mag = int'(dz_now) + $urandom_range(0, 4) - 2;
            2: mag = 32767 - $urandom_range(0, 1);
            3: mag = 16384 + $urandom_range(0, 2) - 1;
            4: mag = $urandom_range(0, 63);
            default: mag = -1;
        endcase
        if (mag < 0) begin
            s.stick = 16'($urandom);
        end else begin
            if (mag > 32767) mag = 32767;
            s.stick = 16'($urandom_range(0, 1) ? -mag : mag);
            if (mag == 32767 && $urandom_range(0, 3) == 0) s.stick = 16'h8000;
        end
        case ($urandom_range(0, 3))
            0: begin
                s.tr = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
                s.tl = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
            end
            1: begin
                s.tr = 15'(16383 + $urandom_range(0, 1));
                s.tl = 15'(16383 + $urandom_range(0, 1));
            end
            default: begin
                s.tr = 15'($urandom);
                s.tl = 15'($urandom);
            end
        endcase
        keep  = 4'($urandom);
        s.btn = t_buttons'((last_btn & keep) | (4'($urandom) & ~keep));
        return s;
    endfunction

    // Offer one sample and hold it until the transaction completes.
    task automatic send_sample(input sample_t s);
        u_sample_if.valid         <= 1'b1;
        u_sample_if.stick_x       <= s.stick;
        u_sample_if.trigger_right <= s.tr;
        u_sample_if.trigger_left  <= s.tl;
        u_sample_if.button_a      <= s.btn.a;
        u_sample_if.button_b      <= s.btn.b;
        u_sample_if.button_x      <= s.btn.x;
        u_sample_if.button_y      <= s.btn.y;
        do @(posedge clk); while (!u_sample_if.ready);
        sent++;
        last_btn = s.btn;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            u_sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    // Stop offering samples and wait for every outstanding command.
    task automatic drain_commands();
        u_sample_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Load new thresholds while the block is idle, then probe the stick at zero and at both extremes.
    task automatic retune(input logic [14:0] dz, input logic [15:0] gain);
        sample_t probe[3];
        drain_commands();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_DEADZONE;
        cfg_wdata <= CFG_DATA_W'(dz);
        @(posedge clk);
        cfg_idx   <= REG_GAIN;
        cfg_wdata <= gain;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dz_now = dz;
        settings++;
        probe[0] = make_sample(0, 0, 0, BTN_NONE);
        probe[1] = make_sample(-32768, 32767, 0, BTN_NONE);
        probe[2] = make_sample(32767, 0, 32767, BTN_NONE);
        foreach (probe[i]) send_sample(probe[i]);
    endtask

    // Command side: ready in random bursts, with one long hold-off on request.
    initial begin
        u_cmd_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                u_cmd_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                u_cmd_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                u_cmd_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Sample side and the run sequence.
    initial begin
        sample_t directed[20];
        u_sample_if.valid         <= 1'b0;
        u_sample_if.stick_x       <= '0;
        u_sample_if.trigger_right <= '0;
        u_sample_if.trigger_left  <= '0;
        u_sample_if.button_a      <= 1'b0;
        u_sample_if.button_b      <= 1'b0;
        u_sample_if.button_x      <= 1'b0;
        u_sample_if.button_y      <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_DEADZONE;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset thresholds: axis and trigger extremes, the
        // deadzone edge, half scale, arming, estop, both together, lights and modes.
        directed = '{
            make_sample(-32768,     0,     0, BTN_NONE),
            make_sample( 32767, 32767,     0, BTN_A),
            make_sample(     0,     0, 32767, BTN_NONE),
            make_sample(  3276, 16383, 16384, BTN_B),
            make_sample(  3277, 16384, 16383, BTN_NONE),
            make_sample( -3277, 32767, 32767, BTN_A | BTN_B),
            make_sample( -3278,     1,     0, BTN_NONE),
            make_sample( 16383,     0,     1, BTN_A),
            make_sample( 16384, 12345,   678, BTN_A),
            make_sample(    -1,     0,     0, BTN_Y),
            make_sample(     1,     0,     0, BTN_NONE),
            make_sample(-16384, 16384,     0, BTN_X),
            make_sample( 32766,     0, 16384, BTN_NONE),
            make_sample(-32767,  5000,  7000, BTN_X),
            make_sample(  3278, 32767, 16383, BTN_NONE),
            make_sample(-16385,   100,   100, BTN_X),
            make_sample( 20000,  9999,     0, BTN_X | BTN_Y),
            make_sample(-20000,     0,  9999, BTN_NONE),
            make_sample(  8000, 30000,  2000, BTN_A | BTN_B | BTN_X | BTN_Y),
            make_sample( -8000,  2000, 30000, BTN_NONE)
        };
        foreach (directed[i]) send_sample(directed[i]);

        // Unity gain with no deadzone, so the stick passes straight through.
        retune(15'd0, 16'd16384);
        run_random(120);

        // Largest thresholds; the command side holds off while samples keep coming.
        retune(15'd32767, 16'd65535);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        run_random(40);
        gaps_on = 1'b1;
        run_random(80);

        // Small deadzone with the largest gain drives steering into saturation.
        retune(15'd1000, 16'd65535);
        stalls_on = 1'b0;
        run_random(120);

        retune(15'($urandom_range(0, 32767)), 16'($urandom_range(16384, 65535)));
        stalls_on = 1'b1;
        gaps_on   = 1'b0;
        run_random(120);

        // Back to the reset thresholds, at full rate on both sides.
        retune(DEADZONE_RESET, GAIN_RESET);
        stalls_on = 1'b0;
        run_random(150);

        drain_commands();
        repeat (8) @(posedge clk);

        $display("Covered %0d controller samples across %0d threshold settings; %0d commands checked.",
                 sent, settings + 1, checked);
        $display("Command side held off %0d time(s) for %0d cycles; %0d failure(s) recorded.",
                 holds_done, LONG_HOLD, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/gdcm_pkg.sv
rtl/gdcm_in_if.sv
rtl/gdcm_out_if.sv
rtl/gdcm_analog.sv
rtl/gdcm_buttons.sv
rtl/gamepad_drive_command_mapper.sv
sim/gdcm_cmd_checker.sv
sim/tb_gamepad_drive_command_mapper.sv
